[src/bslc_pkg.sv]
// ----------------------------------------------------------------------------
// bslc_pkg
// Shared types and codes for the blind stepper limit controller: request and
// result payloads, command codes and motion state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bslc_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_OPEN  = 3'd1;
    localparam logic [2:0] CMD_CLOSE = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_SET   = 3'd4;
    localparam logic [2:0] CMD_INIT  = 3'd5;

    // Motion state codes, as seen on the result
    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_OPENING = 2'd1;
    localparam logic [1:0] ST_CLOSING = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STEP_INTERVAL   = 2'd0;
    localparam logic [1:0] CFG_OVERTRAVEL      = 2'd1;
    localparam logic [1:0] CFG_REPORT_INTERVAL = 2'd2;
    localparam logic [1:0] CFG_SAVED_OPEN      = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] STEP_INTERVAL_RST   = 16'd1000;
    localparam logic [15:0] OVERTRAVEL_RST      = 16'd400;
    localparam logic [23:0] REPORT_INTERVAL_RST = 24'd1000000;

    // Positions
    localparam logic [6:0] POS_OPEN   = 7'd100;
    localparam logic [6:0] POS_CLOSED = 7'd0;
    localparam logic [6:0] POS_HALF   = 7'd50;

    localparam logic [23:0] REPORT_TIMER_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] target_percent;
        logic       top_covered;
        logic       bottom_covered;
    } t_in_item;

    typedef struct packed {
        logic       step_pulse;
        logic       driver_enable;
        logic       direction_up;
        logic [1:0] motion_state;
        logic [6:0] position;
        logic       save_valid;
        logic       save_open;
        logic       report_valid;
        logic [6:0] report_position;
        logic [1:0] report_state;
    } t_out_item;

endpackage

`default_nettype wire

[src/blind_stepper_limit_controller_core.sv]
// ----------------------------------------------------------------------------
// blind_stepper_limit_controller_core
// Roller blind stepper controller: tick-driven step pulses, limit sensor
// overtravel countdown, end position tracking, save and report flags.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+--------------------------
//  in      | sink      | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | source    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One request per cycle sustained while the result side keeps up; each
//  accepted request passes the input register, then the result register.
//  The state update is one short pass of compares and counter steps.
//  A stalled result holds in the result register while one further request
//  waits in the input register; o_in_ready drops only when both are full.
//  Reset (synchronous, active low) clears control state and loads the
//  configuration reset values; the cfg port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module blind_stepper_limit_controller_core
    import bslc_pkg::*;
#(
    parameter int STEP_TIMER_BITS = 16,
    parameter int OVERTRAVEL_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    localparam int CMP_W = (STEP_TIMER_BITS > 16) ? STEP_TIMER_BITS : 16;
    localparam int OT_W  = (OVERTRAVEL_BITS > 16) ? OVERTRAVEL_BITS : 16;
    localparam logic [STEP_TIMER_BITS-1:0] STEP_TIMER_MAX = '1;

    // Configuration registers
    logic [15:0] r_step_interval;
    logic [15:0] r_overtravel_steps;
    logic [23:0] r_report_interval;
    logic        r_saved_open;

    // Controller state
    logic [1:0]                 r_motion,          n_motion;
    logic                       r_last_end_open,   n_last_end_open;
    logic [OVERTRAVEL_BITS-1:0] r_overtravel_left, n_overtravel_left;
    logic [STEP_TIMER_BITS-1:0] r_step_timer,      n_step_timer;
    logic [23:0]                r_report_timer,    n_report_timer;
    logic                       r_dir_up,          n_dir_up;
    logic                       r_driver_on,       n_driver_on;

    // Pipeline registers
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic advance;
    logic in_accept;

    // Position from the sensors and the last known end
    function automatic logic [6:0] f_position(input logic top, input logic bottom,
                                              input logic end_open);
        logic [6:0] pos;
        if (!top && !bottom) begin
            pos = POS_OPEN;
        end else if (bottom) begin
            pos = POS_CLOSED;
        end else begin
            pos = end_open ? POS_OPEN : POS_CLOSED;
        end
        return pos;
    endfunction

    // Handshake
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval    <= STEP_INTERVAL_RST;
            r_overtravel_steps <= OVERTRAVEL_RST;
            r_report_interval  <= REPORT_INTERVAL_RST;
            r_saved_open       <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP_INTERVAL:   r_step_interval    <= i_cfg_data[15:0];
                CFG_OVERTRAVEL:      r_overtravel_steps <= i_cfg_data[15:0];
                CFG_REPORT_INTERVAL: r_report_interval  <= i_cfg_data;
                CFG_SAVED_OPEN:      r_saved_open       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next state and result for the request in the input register
    always_comb begin
        logic                       top;
        logic                       bottom;
        logic                       do_open;
        logic                       do_close;
        logic [STEP_TIMER_BITS-1:0] elapsed;
        logic [OT_W-1:0]            ot_ext;
        logic [OVERTRAVEL_BITS-1:0] ot_cur;
        logic                       fin;

        top      = r_in_item.top_covered;
        bottom   = r_in_item.bottom_covered;
        do_open  = (r_in_item.command == CMD_OPEN) ||
                   ((r_in_item.command == CMD_SET) && (r_in_item.target_percent >= POS_HALF));
        do_close = (r_in_item.command == CMD_CLOSE) ||
                   ((r_in_item.command == CMD_SET) && (r_in_item.target_percent < POS_HALF));
        elapsed  = (r_step_timer != STEP_TIMER_MAX) ? r_step_timer + 1'b1 : r_step_timer;
        ot_ext   = OT_W'(r_overtravel_steps);
        ot_cur   = r_overtravel_left;
        fin      = (r_motion == ST_OPENING);

        n_motion          = r_motion;
        n_last_end_open   = r_last_end_open;
        n_overtravel_left = r_overtravel_left;
        n_step_timer      = r_step_timer;
        n_report_timer    = r_report_timer;
        n_dir_up          = r_dir_up;
        n_driver_on       = r_driver_on;
        n_out_item        = '0;

        if (do_open || do_close) begin
            if (do_open && !top && r_last_end_open) begin
                // already open: report only
                n_out_item.report_valid    = 1'b1;
                n_out_item.report_position = POS_OPEN;
                n_out_item.report_state    = ST_STOPPED;
            end else if (do_close && bottom && !r_last_end_open) begin
                // already closed: report only
                n_out_item.report_valid    = 1'b1;
                n_out_item.report_position = POS_CLOSED;
                n_out_item.report_state    = ST_STOPPED;
            end else begin
                n_overtravel_left          = '0;
                n_motion                   = do_open ? ST_OPENING : ST_CLOSING;
                n_dir_up                   = do_open;
                n_driver_on                = 1'b1;
                n_step_timer               = '0;
                n_report_timer             = '0;
                n_out_item.report_valid    = 1'b1;
                n_out_item.report_position = f_position(top, bottom, r_last_end_open);
                n_out_item.report_state    = do_open ? ST_OPENING : ST_CLOSING;
            end
        end else if (r_in_item.command == CMD_STOP) begin
            if (r_motion != ST_STOPPED) begin
                n_motion          = ST_STOPPED;
                n_overtravel_left = '0;
                n_driver_on       = 1'b0;
                if (!top) begin
                    n_last_end_open = 1'b1;
                end else if (bottom) begin
                    n_last_end_open = 1'b0;
                end
                n_out_item.save_valid      = 1'b1;
                n_out_item.save_open       = n_last_end_open;
                n_out_item.report_valid    = 1'b1;
                n_out_item.report_position = n_last_end_open ? POS_OPEN : POS_CLOSED;
                n_out_item.report_state    = ST_STOPPED;
            end
        end else if (r_in_item.command == CMD_INIT) begin
            n_driver_on       = 1'b0;
            n_dir_up          = 1'b1;
            n_last_end_open   = r_saved_open;
            n_overtravel_left = '0;
            if (!top && !bottom) begin
                n_last_end_open       = 1'b1;
                n_out_item.save_valid = 1'b1;
                n_out_item.save_open  = 1'b1;
            end else if (top && bottom) begin
                n_last_end_open       = 1'b0;
                n_out_item.save_valid = 1'b1;
                n_out_item.save_open  = 1'b0;
            end
        end else if ((r_in_item.command == CMD_TICK) && (r_motion != ST_STOPPED)) begin
            // limit seen with no countdown running: load overtravel
            if ((ot_cur == '0) &&
                (((r_motion == ST_OPENING) && !top) || ((r_motion == ST_CLOSING) && bottom))) begin
                ot_cur = ot_ext[OVERTRAVEL_BITS-1:0];
            end
            n_overtravel_left = ot_cur;
            n_report_timer    = (r_report_timer != REPORT_TIMER_MAX) ?
                                r_report_timer + 24'd1 : r_report_timer;

            if (CMP_W'(elapsed) < CMP_W'(r_step_interval)) begin
                n_step_timer = elapsed;
            end else begin
                n_step_timer          = '0;
                n_out_item.step_pulse = 1'b1;
                if ((ot_cur != '0) && (ot_cur == OVERTRAVEL_BITS'(1))) begin
                    // countdown ends: stop at the end of travel
                    n_overtravel_left          = '0;
                    n_motion                   = ST_STOPPED;
                    n_driver_on                = 1'b0;
                    n_last_end_open            = fin;
                    n_out_item.save_valid      = 1'b1;
                    n_out_item.save_open       = fin;
                    n_out_item.report_valid    = 1'b1;
                    n_out_item.report_position = fin ? POS_OPEN : POS_CLOSED;
                    n_out_item.report_state    = ST_STOPPED;
                end else begin
                    if (ot_cur != '0) begin
                        n_overtravel_left = ot_cur - 1'b1;
                    end
                    // periodic progress report
                    if (n_report_timer >= r_report_interval) begin
                        n_report_timer             = '0;
                        n_out_item.report_valid    = 1'b1;
                        n_out_item.report_position = f_position(top, bottom, r_last_end_open);
                        n_out_item.report_state    = r_motion;
                    end
                end
            end
        end

        n_out_item.driver_enable = n_driver_on;
        n_out_item.direction_up  = n_dir_up;
        n_out_item.motion_state  = n_motion;
        n_out_item.position      = f_position(top, bottom, n_last_end_open);
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // Controller state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion          <= ST_STOPPED;
            r_last_end_open   <= 1'b1;
            r_overtravel_left <= '0;
            r_step_timer      <= '0;
            r_report_timer    <= '0;
            r_dir_up          <= 1'b1;
            r_driver_on       <= 1'b0;
        end else if (advance) begin
            r_motion          <= n_motion;
            r_last_end_open   <= n_last_end_open;
            r_overtravel_left <= n_overtravel_left;
            r_step_timer      <= n_step_timer;
            r_report_timer    <= n_report_timer;
            r_dir_up          <= n_dir_up;
            r_driver_on       <= n_driver_on;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

`default_nettype wire

[tb/tb_blind_stepper_limit_controller_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blind_stepper_limit_controller_core
// Self-checking bench for the blind stepper controller core. A short scripted
// sequence covers the corner cases: unknown codes, ignored open and close,
// init while moving, and stop at either end. Random motion episodes follow,
// with sensor levels that move the way the fabric would, plus some noise
// requests. Results are checked against scripted values or an in-bench model
// of the motion, overtravel and timer logic. Registers change between phases.
// ----------------------------------------------------------------------------
module tb_blind_stepper_limit_controller_core;
    import bslc_pkg::*;

    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 6;
    localparam int SCRIPT_SPLIT   = 15;
    localparam int PRESSURE_PHASE = 2;
    localparam int PAUSE_PHASE    = 3;
    localparam int NUM_PHASES     = 7;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam logic [6:0] TARGET_MAX  = 7'd127;

    typedef struct {
        t_in_item  item;
        logic      fixed;
        t_out_item want;
    } t_script_row;

    typedef struct {
        logic [15:0] step_int;
        logic [15:0] ot_steps;
        logic [23:0] rep_int;
        logic        saved;
        logic        bursts;
        int          count;
    } t_phase;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    // Bench control
    logic long_hold = 1'b0;
    logic bursts_on = 1'b1;
    int   mismatches = 0;
    int   accepted   = 0;

    t_out_item   pending_status[$];
    t_script_row script[$];

    // Model registers and state
    logic [15:0] p_step_int   = STEP_INTERVAL_RST;
    logic [15:0] p_ot_steps   = OVERTRAVEL_RST;
    logic [23:0] p_rep_int    = REPORT_INTERVAL_RST;
    logic        p_saved_open = 1'b1;

    logic [1:0]  m_motion   = ST_STOPPED;
    logic        m_last_open = 1'b1;
    logic [15:0] m_ot_left  = '0;
    logic [15:0] m_step_tmr = '0;
    logic [23:0] m_rep_tmr  = '0;
    logic        m_dir_up   = 1'b1;
    logic        m_drv_on   = 1'b0;

    blind_stepper_limit_controller_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial begin
        #5_000_000;
        $display("tb_blind_stepper_limit_controller_core NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Motion model
    // ------------------------------------------------------------------
    function automatic logic [6:0] blind_position(input logic top, input logic bot);
        if (!top && !bot) return POS_OPEN;
        if (bot) return POS_CLOSED;
        return m_last_open ? POS_OPEN : POS_CLOSED;
    endfunction

    function automatic void note_report(inout t_out_item r, input logic [6:0] pos,
                                        input logic [1:0] st);
        r.report_valid    = 1'b1;
        r.report_position = pos;
        r.report_state    = st;
    endfunction

    function automatic void note_save(inout t_out_item r, input logic open);
        r.save_valid = 1'b1;
        r.save_open  = open;
    endfunction

    function automatic void begin_motion(inout t_out_item r, input logic [1:0] st,
                                         input logic top, input logic bot);
        m_ot_left  = '0;
        m_motion   = st;
        m_dir_up   = (st == ST_OPENING);
        m_drv_on   = 1'b1;
        m_step_tmr = '0;
        m_rep_tmr  = '0;
        note_report(r, blind_position(top, bot), st);
    endfunction

    function automatic t_out_item blind_step(input t_in_item it);
        t_out_item   r;
        logic        top, bot, go_up, fin, ended;
        logic [16:0] elapsed;
        r   = '0;
        top = it.top_covered;
        bot = it.bottom_covered;
        case (it.command) inside
            CMD_TICK: begin
                if (m_motion != ST_STOPPED) begin
                    // limit seen: arm the overtravel countdown once
                    if (m_ot_left == '0 && ((m_motion == ST_OPENING && !top) ||
                                            (m_motion == ST_CLOSING && bot)))
                        m_ot_left = p_ot_steps;
                    if (m_rep_tmr != REPORT_TIMER_MAX) m_rep_tmr = m_rep_tmr + 24'd1;
                    elapsed = (m_step_tmr != 16'hFFFF) ? {1'b0, m_step_tmr} + 17'd1
                                                       : 17'h0FFFF;
                    if (elapsed < {1'b0, p_step_int}) begin
                        m_step_tmr = elapsed[15:0];
                    end else begin
                        m_step_tmr   = '0;
                        r.step_pulse = 1'b1;
                        ended        = 1'b0;
                        if (m_ot_left != '0) begin
                            m_ot_left = m_ot_left - 16'd1;
                            if (m_ot_left == '0) begin
                                fin         = (m_motion == ST_OPENING);
                                m_motion    = ST_STOPPED;
                                m_drv_on    = 1'b0;
                                m_last_open = fin;
                                note_save(r, fin);
                                note_report(r, fin ? POS_OPEN : POS_CLOSED, ST_STOPPED);
                                ended = 1'b1;
                            end
                        end
                        if (!ended && m_rep_tmr >= p_rep_int) begin
                            m_rep_tmr = '0;
                            note_report(r, blind_position(top, bot), m_motion);
                        end
                    end
                end
            end
            CMD_OPEN, CMD_CLOSE, CMD_SET: begin
                go_up = (it.command == CMD_OPEN) ||
                        (it.command == CMD_SET && it.target_percent >= POS_HALF);
                if (go_up) begin
                    if (!top && m_last_open) note_report(r, POS_OPEN, ST_STOPPED);
                    else begin_motion(r, ST_OPENING, top, bot);
                end else begin
                    if (bot && !m_last_open) note_report(r, POS_CLOSED, ST_STOPPED);
                    else begin_motion(r, ST_CLOSING, top, bot);
                end
            end
            CMD_STOP: begin
                if (m_motion != ST_STOPPED) begin
                    m_motion  = ST_STOPPED;
                    m_ot_left = '0;
                    m_drv_on  = 1'b0;
                    if (!top) m_last_open = 1'b1;
                    else if (bot) m_last_open = 1'b0;
                    note_save(r, m_last_open);
                    note_report(r, m_last_open ? POS_OPEN : POS_CLOSED, ST_STOPPED);
                end
            end
            CMD_INIT: begin
                // motion state and timers are left alone
                m_drv_on    = 1'b0;
                m_dir_up    = 1'b1;
                m_last_open = p_saved_open;
                m_ot_left   = '0;
                if (!top && !bot) begin
                    m_last_open = 1'b1;
                    note_save(r, 1'b1);
                end else if (top && bot) begin
                    m_last_open = 1'b0;
                    note_save(r, 1'b0);
                end
            end
            default: ;
        endcase
        r.driver_enable = m_drv_on;
        r.direction_up  = m_dir_up;
        r.motion_state  = m_motion;
        r.position      = blind_position(top, bot);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        t_out_item exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (pending_status.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
            end else begin
                exp_r = pending_status.pop_front();
                if (out_item !== exp_r) begin
                    mismatches++;
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, exp_r, out_item);
                end
            end
        end
    end

    // Result side stalls: random bursts, plus one long hold on request
    initial begin : result_side
        int n;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
                long_hold <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 19);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic t_in_item req(input logic [2:0] cmd, input logic [6:0] tgt,
                                     input logic top, input logic bot);
        t_in_item it;
        it.command        = cmd;
        it.target_percent = tgt;
        it.top_covered    = top;
        it.bottom_covered = bot;
        return it;
    endfunction

    function automatic t_out_item want(input logic drv, input logic dir,
                                       input logic [1:0] st, input logic [6:0] pos,
                                       input logic sv, input logic svo, input logic rv,
                                       input logic [6:0] rpos, input logic [1:0] rstate);
        t_out_item r;
        r = '{1'b0, drv, dir, st, pos, sv, svo, rv, rpos, rstate};
        return r;
    endfunction

    function automatic void row(input t_in_item it, input logic fixed, input t_out_item w);
        t_script_row s;
        s.item  = it;
        s.fixed = fixed;
        s.want  = w;
        script.push_back(s);
    endfunction

    task automatic offer(input t_in_item it, input logic fixed, input t_out_item w);
        t_out_item predicted;
        int        gap;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        predicted = blind_step(it);
        pending_status.push_back(fixed ? w : predicted);
        accepted++;
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle(input int extra);
        in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_STEP_INTERVAL:   p_step_int   = val[15:0];
            CFG_OVERTRAVEL:      p_ot_steps   = val[15:0];
            CFG_REPORT_INTERVAL: p_rep_int    = val;
            CFG_SAVED_OPEN:      p_saved_open = val[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] si, input logic [15:0] ot,
                                input logic [23:0] ri, input logic sv);
        reg_write(CFG_STEP_INTERVAL, {8'd0, si});
        reg_write(CFG_OVERTRAVEL, {8'd0, ot});
        reg_write(CFG_REPORT_INTERVAL, ri);
        reg_write(CFG_SAVED_OPEN, {23'd0, sv});
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item random_request();
        return req(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // One motion episode: start command, then ticks while the fabric passes the
    // sensors (bottom clears before top going up, top covers first going down)
    task automatic run_episode();
        logic     opening;
        int       kt, kb, tmp, lim, stp, ticks, r;
        t_in_item it;
        opening = 1'($urandom_range(0, 1));
        kt = $urandom_range(0, 15);
        kb = $urandom_range(0, 15);
        if (opening ? (kb > kt) : (kt > kb)) begin
            tmp = kt;
            kt  = kb;
            kb  = tmp;
        end
        lim = (p_ot_steps == 16'd0 || p_ot_steps > 16'd12) ? 12 : int'(p_ot_steps);
        stp = (p_step_int == 16'd0) ? 1 : (p_step_int > 16'd6) ? 6 : int'(p_step_int);
        ticks = ((kt > kb) ? kt : kb) + lim * stp + $urandom_range(0, 6);
        if (ticks > 90) ticks = 90;
        r = $urandom_range(0, 19);
        if (r == 19) begin
            it = random_request();
            it.command = CMD_INIT;
            offer(it, 1'b0, '0);
            return;
        end
        for (int i = 0; i <= ticks; i++) begin
            it = '0;
            it.top_covered    = opening ? (i < kt) : (i >= kt);
            it.bottom_covered = opening ? (i < kb) : (i >= kb);
            if ($urandom_range(0, 31) == 0) begin
                it.top_covered    = it.top_covered ^ 1'($urandom_range(0, 1));
                it.bottom_covered = it.bottom_covered ^ 1'($urandom_range(0, 1));
            end
            if (i == 0) begin
                if (r < 13) begin
                    it.command = opening ? CMD_OPEN : CMD_CLOSE;
                end else begin
                    it.command        = CMD_SET;
                    it.target_percent = opening ? 7'($urandom_range(50, 127))
                                                : 7'($urandom_range(0, 49));
                end
            end else if ($urandom_range(0, 24) == 0) begin
                it = random_request();
            end else begin
                it.command = CMD_TICK;
            end
            offer(it, 1'b0, '0);
        end
        if ($urandom_range(0, 1) == 1) begin
            it.command = CMD_STOP;
            offer(it, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_phase phases[NUM_PHASES];
        int     base;
        logic   held, paused;

        phases[0] = '{16'd2,     16'd3,     24'd5,        1'b1, 1'b1, 170};
        phases[1] = '{16'd0,     16'd1,     24'd0,        1'b0, 1'b1, 150};
        phases[2] = '{16'd1,     16'd0,     24'd4,        1'b1, 1'b0, 150};
        phases[3] = '{16'd3,     16'd65535, 24'd16777215, 1'b0, 1'b1, 130};
        phases[4] = '{16'd65535, 16'd1,     24'd1,        1'b1, 1'b1, 100};
        phases[5] = '{16'd1,     16'd1,     24'd2,        1'b0, 1'b1, 220};
        phases[6] = '{16'd4,     16'd5,     24'd20,       1'b1, 1'b0, 200};

        // Reset values: last end open, saved open, stopped
        row(req(CMD_TICK, 7'd0, 1'b0, 1'b0), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_OPEN, 1'b0, 1'b0, 1'b0, POS_CLOSED, ST_STOPPED));
        row(req(CMD_SPARE_7, TARGET_MAX, 1'b1, 1'b1), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_CLOSED, 1'b0, 1'b0, 1'b0, POS_CLOSED, ST_STOPPED));
        row(req(CMD_SPARE_6, 7'd0, 1'b1, 1'b0), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_OPEN, 1'b0, 1'b0, 1'b0, POS_CLOSED, ST_STOPPED));
        row(req(CMD_STOP, 7'd0, 1'b0, 1'b0), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_OPEN, 1'b0, 1'b0, 1'b0, POS_CLOSED, ST_STOPPED));
        // open while already open is ignored
        row(req(CMD_OPEN, 7'd0, 1'b0, 1'b0), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_OPEN, 1'b0, 1'b0, 1'b1, POS_OPEN, ST_STOPPED));
        // init with both covered saves closed
        row(req(CMD_INIT, 7'd0, 1'b1, 1'b1), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_CLOSED, 1'b1, 1'b0, 1'b0, POS_CLOSED, ST_STOPPED));
        row(req(CMD_CLOSE, 7'd0, 1'b1, 1'b1), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_CLOSED, 1'b0, 1'b0, 1'b1, POS_CLOSED, ST_STOPPED));
        row(req(CMD_SET, 7'd0, 1'b1, 1'b1), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_CLOSED, 1'b0, 1'b0, 1'b1, POS_CLOSED, ST_STOPPED));
        row(req(CMD_INIT, 7'd0, 1'b0, 1'b0), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_OPEN, 1'b1, 1'b1, 1'b0, POS_CLOSED, ST_STOPPED));
        row(req(CMD_INIT, 7'd0, 1'b1, 1'b0), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_OPEN, 1'b0, 1'b0, 1'b0, POS_CLOSED, ST_STOPPED));
        row(req(CMD_CLOSE, 7'd0, 1'b1, 1'b0), 1'b1,
            want(1'b1, 1'b0, ST_CLOSING, POS_OPEN, 1'b0, 1'b0, 1'b1, POS_OPEN, ST_CLOSING));
        row(req(CMD_TICK, 7'd0, 1'b1, 1'b0), 1'b1,
            want(1'b1, 1'b0, ST_CLOSING, POS_OPEN, 1'b0, 1'b0, 1'b0, POS_CLOSED, ST_STOPPED));
        // init while moving drops the driver but keeps the motion state
        row(req(CMD_INIT, 7'd0, 1'b1, 1'b0), 1'b1,
            want(1'b0, 1'b1, ST_CLOSING, POS_OPEN, 1'b0, 1'b0, 1'b0, POS_CLOSED, ST_STOPPED));
        row(req(CMD_TICK, 7'd0, 1'b1, 1'b0), 1'b1,
            want(1'b0, 1'b1, ST_CLOSING, POS_OPEN, 1'b0, 1'b0, 1'b0, POS_CLOSED, ST_STOPPED));
        row(req(CMD_STOP, 7'd0, 1'b1, 1'b1), 1'b1,
            want(1'b0, 1'b1, ST_STOPPED, POS_CLOSED, 1'b1, 1'b0, 1'b1, POS_CLOSED, ST_STOPPED));
        // Fast settings: full open with overtravel, ignored set, full close
        row(req(CMD_SET, TARGET_MAX, 1'b1, 1'b1), 1'b0, '0);
        row(req(CMD_TICK, 7'd0, 1'b1, 1'b0), 1'b0, '0);
        row(req(CMD_TICK, 7'd0, 1'b0, 1'b0), 1'b0, '0);
        row(req(CMD_TICK, 7'd0, 1'b0, 1'b0), 1'b0, '0);
        row(req(CMD_TICK, 7'd0, 1'b0, 1'b0), 1'b0, '0);
        row(req(CMD_SET, POS_HALF, 1'b0, 1'b0), 1'b0, '0);
        row(req(CMD_SET, 7'd49, 1'b0, 1'b0), 1'b0, '0);
        row(req(CMD_TICK, 7'd0, 1'b1, 1'b1), 1'b0, '0);
        row(req(CMD_TICK, 7'd0, 1'b1, 1'b1), 1'b0, '0);
        row(req(CMD_TICK, 7'd0, 1'b1, 1'b1), 1'b0, '0);
        row(req(CMD_INIT, 7'd0, 1'b1, 1'b0), 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Scripted part
        foreach (script[k]) begin
            if (k == SCRIPT_SPLIT) begin
                settle(DRAIN_CYCLES);
                program_regs(16'd1, 16'd2, 24'd3, 1'b0);
            end
            offer(script[k].item, script[k].fixed, script[k].want);
        end

        // Random episodes, one register setting per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle(DRAIN_CYCLES);
            program_regs(phases[p].step_int, phases[p].ot_steps,
                         phases[p].rep_int, phases[p].saved);
            bursts_on = phases[p].bursts;
            base   = accepted;
            held   = 1'b0;
            paused = 1'b0;
            while (accepted - base < phases[p].count) begin
                if (p == PRESSURE_PHASE && !held && accepted - base >= 40) begin
                    long_hold <= 1'b1;
                    held = 1'b1;
                end
                if (p == PAUSE_PHASE && !paused && accepted - base >= 60) begin
                    settle(1);
                    paused = 1'b1;
                end
                run_episode();
            end
        end

        settle(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("tb_blind_stepper_limit_controller_core OK");
        else
            $display("tb_blind_stepper_limit_controller_core NOT OK");
        $finish;
    end

endmodule
